>>> src/ogro_pkg.sv
// ----------------------------------------------------------------------------
// ogro_pkg: shared types and constants of the occupancy grid ray occlusion core
// Request and result payloads, configuration register indexes, query modes and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ogro_pkg;

  // Width of the cell size register (unsigned fixed point).
  localparam int CS_W = 31;

  // Query modes carried in a request. The spare code is dropped without a result.
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_OCCL  = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CELL_SIZE   = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_X    = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Y    = 3'd2;
  localparam logic [2:0] CFG_COLUMNS     = 3'd3;
  localparam logic [2:0] CFG_ROWS        = 3'd4;
  localparam logic [2:0] CFG_THRESHOLD   = 3'd5;
  localparam logic [2:0] CFG_GRID_PRESENT = 3'd6;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        cell_index;
    logic signed [7:0]  cell_value;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
  } ogro_in_t;

  typedef struct packed {
    logic [1:0] query_kind;
    logic       answer;
  } ogro_out_t;

  typedef struct packed {
    logic load;
    logic write_cell;
    logic prep;
    logic sq_x;
    logic sq_y;
    logic sq_sum;
    logic root_step;
    logic len_load;
    logic frac_init;
    logic step;
    logic mul_x;
    logic mul_y;
    logic pos;
    logic pt_target;
    logic cell_chk;
    logic idx;
    logic advance;
    logic set_ans;
    logic ans_val;
    logic emit;
  } ogro_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       present;
    logic       root_done;
    logic       short_ray;
    logic       fdiv_busy;
    logic       cdiv_busy;
    logic       pt_out;
    logic       cell_out;
    logic       cell_hit;
    logic       cell_zero;
    logic       more;
    logic       out_busy;
  } ogro_sts_t;

endpackage

>>> src/ogro_ram.sv
// ----------------------------------------------------------------------------
// ogro_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
module ogro_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/ogro_div.sv
// ----------------------------------------------------------------------------
// ogro_div: iterative restoring divider
// Produces one quotient bit per cycle. The caller guarantees that the
// quotient fits in Q_W bits.
// ----------------------------------------------------------------------------
module ogro_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 33,
  parameter int Q_W   = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [Q_W-1:0]   quot,
  output logic [DEN_W-1:0] rem
);

  localparam int W  = DEN_W + Q_W;
  localparam int CW = $clog2(Q_W + 1);

  logic [W-1:0]   rem_r;
  logic [W-1:0]   den_r;
  logic [Q_W-1:0] quot_r;
  logic [CW-1:0]  cnt_r;
  logic           ge;

  assign ge = rem_r >= den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(Q_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= W'(num);
      den_r  <= W'(den) << (Q_W - 1);
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      if (ge) begin
        rem_r <= rem_r - den_r;
      end
      den_r  <= den_r >> 1;
      quot_r <= (quot_r << 1) | Q_W'(ge);
    end
  end

  assign busy = cnt_r != '0;
  assign quot = quot_r;
  assign rem  = rem_r[DEN_W-1:0];

endmodule

>>> src/ogro_ctrl.sv
// ----------------------------------------------------------------------------
// ogro_ctrl: query sequencer
// Walks a request through root, step division, per-sample position,
// cell lookup and result hand-off as its mode requires, one request at a time.
// ----------------------------------------------------------------------------
module ogro_ctrl import ogro_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ogro_sts_t sts,
  output ogro_cmd_t cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_SQX  = 5'd2;
  localparam logic [4:0] S_SQY  = 5'd3;
  localparam logic [4:0] S_SUM  = 5'd4;
  localparam logic [4:0] S_ROOT = 5'd5;
  localparam logic [4:0] S_DIST = 5'd6;
  localparam logic [4:0] S_FDIV = 5'd7;
  localparam logic [4:0] S_STEP = 5'd8;
  localparam logic [4:0] S_MULX = 5'd9;
  localparam logic [4:0] S_MULY = 5'd10;
  localparam logic [4:0] S_POS  = 5'd11;
  localparam logic [4:0] S_CHK  = 5'd12;
  localparam logic [4:0] S_CDIV = 5'd13;
  localparam logic [4:0] S_READ = 5'd14;
  localparam logic [4:0] S_EVAL = 5'd15;
  localparam logic [4:0] S_NEXT = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0] state_r;
  logic [4:0] state_nxt;
  logic       occl;

  assign in_ready = state_r == S_IDLE;
  assign occl     = sts.mode == MODE_OCCL;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.mode)
          MODE_WRITE: begin
            cmd.write_cell = 1'b1;
            state_nxt      = S_IDLE;
          end
          MODE_OCCL: begin
            if (!sts.present) begin
              cmd.set_ans = 1'b1;
              state_nxt   = S_DONE;
            end else begin
              cmd.prep  = 1'b1;
              state_nxt = S_SQX;
            end
          end
          MODE_FREE: begin
            if (!sts.present) begin
              cmd.set_ans = 1'b1;
              cmd.ans_val = 1'b1;
              state_nxt   = S_DONE;
            end else begin
              cmd.pt_target = 1'b1;
              state_nxt     = S_CHK;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SQX: begin
        cmd.sq_x  = 1'b1;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sq_sum = 1'b1;
        state_nxt  = S_ROOT;
      end
      S_ROOT: begin
        if (sts.root_done) begin
          state_nxt = S_DIST;
        end else begin
          cmd.root_step = 1'b1;
        end
      end
      S_DIST: begin
        if (sts.short_ray) begin
          cmd.set_ans = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.len_load = 1'b1;
          state_nxt    = S_FDIV;
        end
      end
      S_FDIV: begin
        if (!sts.fdiv_busy) begin
          cmd.frac_init = 1'b1;
          state_nxt     = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_MULX;
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        state_nxt = S_POS;
      end
      S_POS: begin
        cmd.pos   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.pt_out) begin
          if (occl) begin
            state_nxt = S_NEXT;
          end else begin
            cmd.set_ans = 1'b1;
            state_nxt   = S_DONE;
          end
        end else begin
          cmd.cell_chk = 1'b1;
          state_nxt    = S_CDIV;
        end
      end
      S_CDIV: begin
        if (!sts.cdiv_busy) begin
          if (sts.cell_out) begin
            if (occl) begin
              state_nxt = S_NEXT;
            end else begin
              cmd.set_ans = 1'b1;
              state_nxt   = S_DONE;
            end
          end else begin
            cmd.idx   = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        if (occl) begin
          if (sts.cell_hit) begin
            cmd.set_ans = 1'b1;
            cmd.ans_val = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_NEXT;
          end
        end else begin
          cmd.set_ans = 1'b1;
          cmd.ans_val = sts.cell_zero;
          state_nxt   = S_DONE;
        end
      end
      S_NEXT: begin
        if (sts.more) begin
          cmd.advance = 1'b1;
          state_nxt   = S_STEP;
        end else begin
          cmd.set_ans = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/ogro_dp.sv
// ----------------------------------------------------------------------------
// ogro_dp: datapath of the occupancy grid ray occlusion core
// Configuration registers, cell store, shared multiplier, square root,
// dividers, sample stepping and the result register.
// ----------------------------------------------------------------------------
module ogro_dp import ogro_pkg::*; #(
  parameter int GRID_SIDE = 256,
  parameter int MAX_STEPS = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ogro_in_t    in_data,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  ogro_cmd_t   cmd,
  output ogro_sts_t   sts,
  output logic        out_valid,
  input  logic        out_ready,
  output ogro_out_t   out_data
);

  localparam int GL         = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int DIM_W      = $clog2(GRID_SIDE + 1);
  localparam int IW         = $clog2(MAX_STEPS + 1);
  localparam int CN_W       = CS_W + GL;
  localparam int ACC_W      = 36;
  localparam logic [63:0] MIN_DIST = ((64'd1 << FRAC_BITS) + 64'd99) / 64'd100;

  // Configuration.
  logic [CS_W-1:0]    cs_r;
  logic signed [31:0] ox_r;
  logic signed [31:0] oy_r;
  logic [8:0]         cols_r;
  logic [8:0]         rows_r;
  logic signed [7:0]  thr_r;
  logic               present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r      <= 31'd3277;
      ox_r      <= '0;
      oy_r      <= '0;
      cols_r    <= 9'd256;
      rows_r    <= 9'd256;
      thr_r     <= '0;
      present_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CELL_SIZE:    cs_r      <= cfg_data[CS_W-1:0];
        CFG_ORIGIN_X:     ox_r      <= $signed(cfg_data);
        CFG_ORIGIN_Y:     oy_r      <= $signed(cfg_data);
        CFG_COLUMNS:      cols_r    <= cfg_data[8:0];
        CFG_ROWS:         rows_r    <= cfg_data[8:0];
        CFG_THRESHOLD:    thr_r     <= $signed(cfg_data[7:0]);
        CFG_GRID_PRESENT: present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [CS_W-1:0]  cs_eff;
  logic [DIM_W-1:0] cols_eff;
  logic [DIM_W-1:0] rows_eff;

  assign cs_eff   = (cs_r == '0) ? CS_W'(1) : cs_r;
  assign cols_eff = (32'(cols_r) > 32'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : DIM_W'(cols_r);
  assign rows_eff = (32'(rows_r) > 32'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : DIM_W'(rows_r);

  // Request register.
  ogro_in_t req_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
  end

  // Cell store writes.
  logic [31:0]     widx;
  logic            wr_en;
  logic [AW-1:0]   idx_r;
  logic [7:0]      rd_data;

  assign widx  = 32'(req_r.cell_index);
  assign wr_en = cmd.write_cell && (widx < 32'(CELL_COUNT));

  ogro_ram #(
    .WIDTH (8),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (widx[AW-1:0]),
    .wr_data (req_r.cell_value),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // Ray delta and magnitudes.
  logic signed [32:0] dx_w;
  logic signed [32:0] dy_w;
  logic [32:0]        ax_w;
  logic [32:0]        ay_w;
  logic [32:0]        ax_r;
  logic [32:0]        ay_r;
  logic               neg_x_r;
  logic               neg_y_r;
  logic               sh_r;
  logic [32:0]        axs;
  logic [32:0]        ays;

  assign dx_w = 33'(req_r.target_x) - 33'(req_r.start_x);
  assign dy_w = 33'(req_r.target_y) - 33'(req_r.start_y);
  assign ax_w = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
  assign ay_w = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
  assign axs  = sh_r ? (ax_r >> 1) : ax_r;
  assign ays  = sh_r ? (ay_r >> 1) : ay_r;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      ax_r    <= ax_w;
      ay_r    <= ay_w;
      neg_x_r <= dx_w[32];
      neg_y_r <= dy_w[32];
      sh_r    <= (ax_w[32:31] != 2'b00) || (ay_w[32:31] != 2'b00);
    end
  end

  // Shared multiplier.
  logic [CS_W-1:0] f_r;
  logic            sel_sq;
  logic            sel_y;
  logic [32:0]     mul_a;
  logic [31:0]     mul_b;
  logic [64:0]     prod_w;
  logic [64:0]     prod_r;

  assign sel_sq = cmd.sq_x || cmd.sq_y;
  assign sel_y  = cmd.sq_y || cmd.mul_y;
  assign mul_a  = sel_sq ? (sel_y ? ays : axs) : (sel_y ? ay_r : ax_r);
  assign mul_b  = sel_sq ? mul_a[31:0] : {1'b0, f_r};
  assign prod_w = 65'(mul_a) * 65'(mul_b);

  // Square root, one result bit per cycle.
  logic [63:0] sqv_r;
  logic [63:0] rv_r;
  logic [63:0] rr_r;
  logic [63:0] bit_r;
  logic [63:0] rt_sum;

  assign rt_sum = rr_r + bit_r;

  always_ff @(posedge clk) begin
    if (cmd.sq_x || cmd.sq_y || cmd.mul_x || cmd.mul_y) begin
      prod_r <= prod_w;
    end
    if (cmd.sq_y) begin
      sqv_r <= prod_r[63:0];
    end
    if (cmd.sq_sum) begin
      rv_r  <= sqv_r + prod_r[63:0];
      rr_r  <= '0;
      bit_r <= 64'd1 << 62;
    end else if (cmd.root_step) begin
      if (rv_r >= rt_sum) begin
        rv_r <= rv_r - rt_sum;
        rr_r <= (rr_r >> 1) + bit_r;
      end else begin
        rr_r <= rr_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Ray length and sample fraction.
  logic [32:0]     dist_w;
  logic [33:0]     two_dist_w;
  logic [32:0]     dist_r;
  logic            fdiv_busy;
  logic [CS_W-1:0] fq;
  logic [32:0]     frm;
  logic [32:0]     frem_r;
  logic [33:0]     fsum;
  logic            fcarry;

  assign dist_w     = sh_r ? {rr_r[31:0], 1'b0} : {1'b0, rr_r[31:0]};
  assign two_dist_w = {dist_w, 1'b0};

  ogro_div #(
    .NUM_W (CS_W + 29),
    .DEN_W (33),
    .Q_W   (CS_W)
  ) u_fdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.len_load),
    .num   ({cs_eff, 29'd0}),
    .den   (dist_w),
    .busy  (fdiv_busy),
    .quot  (fq),
    .rem   (frm)
  );

  assign fsum   = 34'(frem_r) + 34'(frm);
  assign fcarry = fsum >= 34'(dist_r);

  // Sample counter and accumulated step length.
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [IW-1:0]    i_r;

  assign acc_nxt = acc_r + ACC_W'(cs_eff);

  always_ff @(posedge clk) begin
    if (cmd.len_load) begin
      dist_r <= dist_w;
      acc_r  <= ACC_W'(cs_eff);
      i_r    <= IW'(1);
    end else if (cmd.advance) begin
      acc_r <= acc_nxt;
      i_r   <= i_r + 1'b1;
    end
    if (cmd.frac_init) begin
      f_r    <= '0;
      frem_r <= '0;
    end else if (cmd.step) begin
      f_r    <= f_r + fq + CS_W'(fcarry);
      frem_r <= fcarry ? 33'(fsum - 34'(dist_r)) : fsum[32:0];
    end
  end

  // Sample point.
  logic [34:0]        offx_r;
  logic signed [35:0] px_r;
  logic signed [35:0] py_r;
  logic signed [35:0] offx_s;
  logic signed [35:0] offy_s;

  assign offx_s = $signed({1'b0, offx_r});
  assign offy_s = $signed({1'b0, prod_r[64:30]});

  always_ff @(posedge clk) begin
    if (cmd.mul_y) begin
      offx_r <= prod_r[64:30];
    end
    if (cmd.pt_target) begin
      px_r <= 36'(req_r.target_x);
      py_r <= 36'(req_r.target_y);
    end else if (cmd.pos) begin
      px_r <= neg_x_r ? 36'(req_r.start_x) - offx_s : 36'(req_r.start_x) + offx_s;
      py_r <= neg_y_r ? 36'(req_r.start_y) - offy_s : 36'(req_r.start_y) + offy_s;
    end
  end

  // Grid range check and cell coordinates. Division truncates toward zero,
  // so a point less than one cell left of or below the origin is column or row 0.
  logic signed [63:0] vx;
  logic signed [63:0] vy;
  logic signed [63:0] cs_s;
  logic signed [63:0] lim_s;
  logic               x_out;
  logic               y_out;
  logic [CN_W-1:0]    numx;
  logic [CN_W-1:0]    numy;
  logic [GL-1:0]      qx;
  logic [GL-1:0]      qy;
  logic               xdiv_busy;
  logic               ydiv_busy;
  logic [31:0]        idx_w;

  assign vx    = 64'(px_r) - 64'(ox_r);
  assign vy    = 64'(py_r) - 64'(oy_r);
  assign cs_s  = $signed(64'(cs_eff));
  assign lim_s = cs_s <<< GL;
  assign x_out = ((vx + cs_s) <= 64'sd0) || (vx >= lim_s);
  assign y_out = ((vy + cs_s) <= 64'sd0) || (vy >= lim_s);
  assign numx  = vx[63] ? '0 : vx[CN_W-1:0];
  assign numy  = vy[63] ? '0 : vy[CN_W-1:0];

  ogro_div #(
    .NUM_W (CN_W),
    .DEN_W (CS_W),
    .Q_W   (GL)
  ) u_xdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cell_chk),
    .num   (numx),
    .den   (cs_eff),
    .busy  (xdiv_busy),
    .quot  (qx),
    .rem   ()
  );

  ogro_div #(
    .NUM_W (CN_W),
    .DEN_W (CS_W),
    .Q_W   (GL)
  ) u_ydiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cell_chk),
    .num   (numy),
    .den   (cs_eff),
    .busy  (ydiv_busy),
    .quot  (qy),
    .rem   ()
  );

  assign idx_w = 32'(qy) * 32'(cols_eff) + 32'(qx);

  always_ff @(posedge clk) begin
    if (cmd.idx) begin
      idx_r <= idx_w[AW-1:0];
    end
  end

  // Result register.
  logic      ans_r;
  logic      out_valid_r;
  ogro_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.set_ans) begin
      ans_r <= cmd.ans_val;
    end
    if (cmd.emit) begin
      out_data_r.query_kind <= req_r.mode;
      out_data_r.answer     <= ans_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status toward the controller.
  always_comb begin
    sts.mode      = req_r.mode;
    sts.present   = present_r;
    sts.root_done = bit_r == '0;
    sts.short_ray = (64'(dist_w) < MIN_DIST) || (34'(cs_eff) > two_dist_w);
    sts.fdiv_busy = fdiv_busy;
    sts.cdiv_busy = xdiv_busy || ydiv_busy;
    sts.pt_out    = x_out || y_out;
    sts.cell_out  = (32'(qx) >= 32'(cols_eff)) || (32'(qy) >= 32'(rows_eff));
    sts.cell_hit  = $signed(rd_data) > thr_r;
    sts.cell_zero = rd_data == 8'd0;
    sts.more      = (i_r != IW'(MAX_STEPS)) && (acc_nxt <= ACC_W'({dist_r, 1'b0}));
    sts.out_busy  = out_valid_r && !out_ready;
  end

endmodule

>>> src/occupancy_grid_ray_occlusion_core.sv
// ----------------------------------------------------------------------------
// occupancy_grid_ray_occlusion_core: occupancy grid with ray occlusion queries
// Holds a grid of signed 8-bit cells and answers occlusion and free-space
// queries against it.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the in_ channel (valid/ready). A write request
// stores one cell and produces no result. An occlusion request returns one
// result telling whether any half-cell sample along the ray hits a cell above
// the threshold; a free-space request returns whether the target cell holds 0.
// Results leave on the out_ channel from an output register, so the core takes
// the next request while a result still waits for the receiver. If the
// receiver stalls, a finished query waits in its last state until the output
// register frees up. Configuration writes on the cfg_ channel are always
// accepted and must only be issued while the core is idle.
// Timing. One request is processed at a time. An occlusion query runs the
// 32-step square root and the 31-step fraction divider, then walks up to
// MAX_STEPS samples, locating each in-grid sample with the two bit-serial
// coordinate dividers.
// Reset. rst_n is synchronous; it restores the register defaults and clears
// the sequencer and the output valid. Cell contents are not cleared.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_occlusion_core import ogro_pkg::*; #(
  parameter int GRID_SIDE = 256,
  parameter int MAX_STEPS = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ogro_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ogro_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ogro_cmd_t cmd;
  ogro_sts_t sts;

  // Registers take a write on any cycle.
  assign cfg_ready = 1'b1;

  // The sequencer decides each step; the datapath holds all state it works on.
  ogro_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ogro_dp #(
    .GRID_SIDE (GRID_SIDE),
    .MAX_STEPS (MAX_STEPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for occupancy_grid_ray_occlusion_core
// Loads small occupancy grids through write requests, then fires occlusion and
// free-space queries under several register settings. A built-in predictor
// keeps its own copy of the grid and registers and computes every answer;
// results are checked in order against it while both channels idle at random, except in the final setting.
// ----------------------------------------------------------------------------
module testbench import ogro_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE = 256;
  localparam int MAX_STEPS = 1024;
  localparam int FRAC_BITS = 16;
  localparam int CYCLE_LIMIT = 100000000;
  localparam int SETTLE = 40;
  localparam int RANDOM_PER_SETTING = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  ogro_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ogro_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  occupancy_grid_ray_occlusion_core #(
    .GRID_SIDE(SIDE),
    .MAX_STEPS(MAX_STEPS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the configuration registers, updated when a register write
  // is accepted. The stimulus generator reads the same copy.
  logic [30:0] cell_size = 31'd3277;
  longint      shadow_ox = 0;
  longint      shadow_oy = 0;
  int          columns = 256;
  int          rows = 256;
  int          threshold = 0;
  bit          grid_loaded = 1'b0;

  // Grid contents as the core should hold them, and the cells that the stimulus
  // has already scheduled a write for, so that no query ever reads a cell that
  // was never written.
  byte grid_mem [SIDE*SIDE];
  bit  scheduled [SIDE*SIDE];

  ogro_in_t  pending_requests [$];
  ogro_out_t expected_answers [$];

  int  error_count = 0;
  int  in_gap = 0;
  int  out_stall = 0;
  bit  quiet = 1'b0;
  int  cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // A cell size of zero behaves as one.
  function automatic longint step_size();
    return (cell_size == 0) ? 64'sd1 : longint'(cell_size);
  endfunction

  // Dimensions above the store side behave as the store side.
  function automatic int dim_in_use(int d);
    return (d > SIDE) ? SIDE : d;
  endfunction

  // Cell under a world point; indices truncate toward zero, so points just
  // left of or below the origin still land on column or row zero.
  function automatic bit cell_at(longint px, longint py, output int val);
    longint cs, gx, gy;
    int c, r;
    cs = step_size();
    gx = (px - shadow_ox) / cs;
    gy = (py - shadow_oy) / cs;
    c = dim_in_use(columns);
    r = dim_in_use(rows);
    val = 0;
    if (gx < 0 || gx >= c || gy < 0 || gy >= r) return 1'b0;
    val = grid_mem[gy * c + gx];
    return 1'b1;
  endfunction

  function automatic longint along(longint d, longint unsigned f);
    longint unsigned mag, off;
    mag = (d < 0) ? -d : d;
    off = (mag * f) >> 30;
    return (d < 0) ? -longint'(off) : longint'(off);
  endfunction

  // Marches the ray in half-cell steps, start point excluded.
  function automatic bit ray_blocked(longint sx, longint sy, longint ex, longint ey);
    longint dx, dy, x, y;
    longint unsigned ax, ay, ray_len, n, f, cs, i;
    int v, sh;
    dx = ex - sx;
    dy = ey - sy;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    cs = step_size();
    sh = 0;
    // Very long rays are halved before squaring so the sum fits in 64 bits.
    if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
      ax >>= 1;
      ay >>= 1;
      sh = 1;
    end
    ray_len = int_root(ax * ax + ay * ay) << sh;
    // Rays shorter than a centimetre are never occluded.
    if (ray_len * 100 < (64'd1 << FRAC_BITS)) return 1'b0;
    n = (2 * ray_len) / cs;
    if (n > MAX_STEPS) n = MAX_STEPS;
    for (i = 1; i <= n; i++) begin
      f = ((i * cs) << 29) / ray_len;
      x = sx + along(dx, f);
      y = sy + along(dy, f);
      if (cell_at(x, y, v) && v > threshold) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic model_request(ogro_in_t req);
    ogro_out_t ans;
    int v;
    case (req.mode)
      MODE_WRITE: grid_mem[req.cell_index] = req.cell_value;
      MODE_OCCL: begin
        ans.query_kind = MODE_OCCL;
        ans.answer = grid_loaded ? ray_blocked(longint'(req.start_x), longint'(req.start_y),
                                               longint'(req.target_x), longint'(req.target_y))
                                 : 1'b0;
        expected_answers.push_back(ans);
      end
      MODE_FREE: begin
        ans.query_kind = MODE_FREE;
        ans.answer = grid_loaded ? (cell_at(longint'(req.target_x), longint'(req.target_y), v)
                                    && v == 0) : 1'b1;
        expected_answers.push_back(ans);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: valid holds until accepted; random gaps between requests.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) model_request(in_data);
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        in_data <= pending_requests.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(5) == 0) in_gap = $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor with random receiver stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result kind=%0d answer=%0d", out_data.query_kind,
                 out_data.answer);
          error_count++;
        end else begin
          if (out_data.query_kind !== expected_answers[0].query_kind) begin
            $error("query_kind expected %0d actual %0d", expected_answers[0].query_kind,
                   out_data.query_kind);
            error_count++;
          end
          if (out_data.answer !== expected_answers[0].answer) begin
            $error("answer expected %0d actual %0d", expected_answers[0].answer,
                   out_data.answer);
            error_count++;
          end
          void'(expected_answers.pop_front());
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(6) == 0) out_stall = $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CELL_SIZE:    cell_size = value[30:0];
      CFG_ORIGIN_X:     shadow_ox = longint'($signed(value));
      CFG_ORIGIN_Y:     shadow_oy = longint'($signed(value));
      CFG_COLUMNS:      columns = value[8:0];
      CFG_ROWS:         rows = value[8:0];
      CFG_THRESHOLD:    threshold = $signed(value[7:0]);
      CFG_GRID_PRESENT: grid_loaded = value[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Waits until every request went in and every answer came back, then lets
  // a trailing write finish before registers may change.
  task automatic drain();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic byte random_cell();
    int r;
    r = $urandom_range(9);
    if (r < 5) return 8'sd0;
    if (r < 7) return -8'sd1;
    return byte'($urandom);
  endfunction

  task automatic push_write(int idx, byte value);
    ogro_in_t req;
    req = ogro_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    req.mode = MODE_WRITE;
    req.cell_index = idx[15:0];
    req.cell_value = value;
    scheduled[idx[15:0]] = 1'b1;
    pending_requests.push_back(req);
  endtask

  task automatic push_query(logic [1:0] mode, longint sx, longint sy, longint tx, longint ty);
    ogro_in_t req;
    req = ogro_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    req.mode = mode;
    req.start_x = sx[31:0];
    req.start_y = sy[31:0];
    req.target_x = tx[31:0];
    req.target_y = ty[31:0];
    pending_requests.push_back(req);
  endtask

  // Writes every cell the current dimensions can reach that has no write yet.
  task automatic load_grid();
    int i;
    for (i = 0; i < dim_in_use(columns) * dim_in_use(rows); i++)
      if (!scheduled[i]) push_write(i, random_cell());
  endtask

  task automatic apply_setting(logic [31:0] cs, logic [31:0] ox, logic [31:0] oy,
                               logic [31:0] c, logic [31:0] r, logic [31:0] th,
                               logic [31:0] present);
    drain();
    reg_write(CFG_CELL_SIZE, cs);
    reg_write(CFG_ORIGIN_X, ox);
    reg_write(CFG_ORIGIN_Y, oy);
    reg_write(CFG_COLUMNS, c);
    reg_write(CFG_ROWS, r);
    reg_write(CFG_THRESHOLD, th);
    reg_write(CFG_GRID_PRESENT, present);
    load_grid();
  endtask

  // A coordinate a little around the grid along one axis.
  function automatic longint near_grid(longint org, int dim);
    longint cs, g;
    cs = step_size();
    g = longint'($urandom_range(0, dim_in_use(dim) + 3)) - 2;
    return org + g * cs + longint'($urandom_range(0, cs - 1));
  endfunction

  // Offset of up to k half cells in either direction.
  function automatic longint ray_offset(int k);
    longint span;
    span = longint'(k) * ((step_size() / 2 > 0) ? step_size() / 2 : 1);
    return longint'($urandom % 4096) * (2 * span + 1) / 4096 - span;
  endfunction

  task automatic random_request();
    int r, k, ce, re;
    longint sx, sy;
    r = $urandom_range(199);
    ce = dim_in_use(columns);
    re = dim_in_use(rows);
    if (r < 90) begin
      // Short to medium ray around the grid; most land on loaded cells.
      sx = near_grid(shadow_ox, columns);
      sy = near_grid(shadow_oy, rows);
      k = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      push_query(MODE_OCCL, sx, sy, sx + ray_offset(k), sy + ray_offset(k));
    end else if (r < 110) begin
      // Rewrite a cell, usually a reachable one, so answers change during the phase.
      if (ce * re > 0 && $urandom_range(3) != 0) push_write($urandom_range(0, ce * re - 1),
                                                             random_cell());
      else push_write($urandom_range(0, SIDE * SIDE - 1), byte'($urandom));
    end else if (r < 120) begin
      push_query(MODE_FREE, longint'($signed($urandom)), longint'($signed($urandom)),
                 longint'($signed($urandom)), longint'($signed($urandom)));
    end else if (r < 121) begin
      // Arbitrary ray; usually marches the full step limit.
      push_query(MODE_OCCL, longint'($signed($urandom)), longint'($signed($urandom)),
                 longint'($signed($urandom)), longint'($signed($urandom)));
    end else if (r < 124) begin
      push_query(MODE_SPARE, longint'($signed($urandom)), longint'($signed($urandom)),
                 longint'($signed($urandom)), longint'($signed($urandom)));
    end else begin
      push_query(MODE_FREE, 0, 0, near_grid(shadow_ox, columns), near_grid(shadow_oy, rows));
    end
  endtask

  task automatic random_phase();
    int i;
    for (i = 0; i < RANDOM_PER_SETTING; i++) random_request();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, no grid loaded: occlusion answers 0, free space 1, an
    // unused mode is dropped and writes to both ends of the store are taken.
    push_query(MODE_OCCL, 0, 0, 32'sd100000, 32'sd50000);
    push_query(MODE_FREE, 0, 0, 32'sd1000, 32'sd1000);
    push_query(MODE_SPARE, 1, 2, 3, 4);
    push_write(SIDE * SIDE - 1, -8'sd128);
    push_write(0, 8'sd127);
    push_query(MODE_FREE, 0, 0, -32'sd1, -32'sd1);

    // Small grid of 5 cm cells with a zero threshold.
    apply_setting(32'd3277, 32'd0, 32'd0, 32'd16, 32'd16, 32'd0, 32'd1);
    push_query(MODE_OCCL, 1000, 1000, 1000 + 655, 1000);
    push_query(MODE_OCCL, 1000, 1000, 1000 + 656, 1000);
    push_query(MODE_OCCL, 100, 100, 16 * 3277, 16 * 3277);
    push_query(MODE_OCCL, 16 * 3277, 0, -1000, 16 * 3277);
    push_query(MODE_OCCL, -32'sd2147483648, -32'sd2147483648, 32'sd2147483647,
               32'sd2147483647);
    push_query(MODE_OCCL, 32'sd2147483647, -32'sd2147483648, -32'sd2147483648, 32'sd2147483647);
    push_query(MODE_FREE, 0, 0, 0, 0);
    push_query(MODE_FREE, 0, 0, -3276, -3276);
    push_query(MODE_FREE, 0, 0, -3277, 0);
    push_query(MODE_FREE, 0, 0, 32'sd2147483647, -32'sd2147483648);
    push_query(MODE_FREE, 0, 0, 15 * 3277 + 3276, 15 * 3277 + 3276);
    random_phase();

    // Zero cell size acts as one; a ray of 2000 units hits the step limit.
    apply_setting(32'd0, -32'sd5, 32'sd7, 32'd8, 32'd8, 32'h80, 32'd1);
    push_query(MODE_OCCL, -5, 7, 1995, 7);
    push_query(MODE_OCCL, 0, 0, 3, 3);
    random_phase();

    // Largest cell, lowest origin, a column count above the store side.
    apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd511, 32'd1, 32'd127, 32'd1);
    push_query(MODE_OCCL, -32'sd2147483648, -32'sd2147483648, 32'sd2147483647,
               -32'sd2147483648);
    random_phase();

    // No columns at all: every point lies outside the grid.
    apply_setting(32'd65536, 32'h7FFF_0000, 32'd12345, 32'd0, 32'd12, 32'd0, 32'd1);
    random_phase();

    // Rows above the store side with a negative threshold.
    apply_setting(32'd1000, -32'sd20000, 32'sd30000, 32'd3, 32'd300, 32'hFF, 32'd1);
    random_phase();

    // Final setting without any idling on either side.
    apply_setting(32'd6554, 32'sd1000, -32'sd1000, 32'd12, 32'd10, 32'd5, 32'd1);
    quiet = 1'b1;
    random_phase();

    drain();
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
